FILE: sv/bicp_pkg.sv
// Shared constants and helpers for the inner Bezier control point unit.
`default_nettype none

package bicp_pkg;

  // Bound on the reduced normal and direction components, as a bit count.
  localparam logic [6:0] NORM_BITS = 7'd19;
  // Bound on the reduced projected direction components, as a bit count.
  localparam logic [6:0] DIR_BITS  = 7'd28;
  // Handle sits at one third of the end-to-end distance.
  localparam logic [1:0] THIRD_DIV = 2'd3;

  // Least right shift that brings v below 2**lim.
  function automatic logic [5:0] fit_shift(input logic [63:0] v, input logic [6:0] lim);
    logic [6:0] bl;
    bl = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        bl = 7'(i + 1);
      end
    end
    return (bl > lim) ? 6'(bl - lim) : 6'd0;
  endfunction

endpackage

`default_nettype wire

FILE: sv/bicp_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband word.
`default_nettype none

module bicp_isqrt
  import bicp_pkg::*;
#(
  parameter int IW = 64,
  parameter int SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [IW-1:0]     rad_i,
  input  logic [SW-1:0]     sb_i,
  output logic              valid_o,
  output logic [IW/2-1:0]   root_o,
  output logic [SW-1:0]     sb_o
);

  localparam int RW = IW / 2;

  logic          v_q  [RW];
  logic [IW-1:0] x_q  [RW];
  logic [IW:0]   r_q  [RW];
  logic [SW-1:0] sb_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    localparam logic [IW:0] BIT = (IW + 1)'(1) << (2 * (RW - 1 - k));

    logic          v_in;
    logic [IW-1:0] x_in;
    logic [IW:0]   r_in;
    logic [SW-1:0] sb_in;
    logic [IW:0]   trial;
    logic [IW-1:0] x_d;
    logic [IW:0]   r_d;

    if (k == 0) begin : g_first
      assign v_in  = valid_i;
      assign x_in  = rad_i;
      assign r_in  = '0;
      assign sb_in = sb_i;
    end else begin : g_next
      assign v_in  = v_q[k-1];
      assign x_in  = x_q[k-1];
      assign r_in  = r_q[k-1];
      assign sb_in = sb_q[k-1];
    end

    always_comb begin
      trial = r_in + BIT;
      if ({1'b0, x_in} >= trial) begin
        x_d = x_in - trial[IW-1:0];
        r_d = (r_in >> 1) + BIT;
      end else begin
        x_d = x_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]  <= x_d;
        r_q[k]  <= r_d;
        sb_q[k] <= sb_in;
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = r_q[RW-1][RW-1:0];
  assign sb_o    = sb_q[RW-1];

endmodule

`default_nettype wire

FILE: sv/bicp_div.sv
// Pipelined restoring divider, several lanes over one divisor, one quotient bit per stage.
`default_nettype none

module bicp_div
  import bicp_pkg::*;
#(
  parameter int LANES = 3,
  parameter int NW    = 62,
  parameter int DW    = 31,
  parameter int QW    = 32,
  parameter int SW    = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [LANES-1:0][NW-1:0]   num_i,
  input  logic [DW-1:0]              den_i,
  input  logic [SW-1:0]              sb_i,
  output logic                       valid_o,
  output logic [LANES-1:0][QW-1:0]   quo_o,
  output logic [SW-1:0]              sb_o
);

  // Quotient is known to fit QW bits, so the high part of the numerator is below the divisor.
  logic                        v_q   [QW];
  logic [LANES-1:0][NW-1:0]    num_q [QW];
  logic [LANES-1:0][DW:0]      rem_q [QW];
  logic [LANES-1:0][QW-1:0]    quo_q [QW];
  logic [DW-1:0]               den_q [QW];
  logic [SW-1:0]               sb_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic                      v_in;
    logic [LANES-1:0][NW-1:0]  num_in;
    logic [LANES-1:0][DW:0]    rem_in;
    logic [LANES-1:0][QW-1:0]  quo_in;
    logic [DW-1:0]             den_in;
    logic [SW-1:0]             sb_in;
    logic [LANES-1:0][DW:0]    rem_d;
    logic [LANES-1:0][QW-1:0]  quo_d;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign num_in = num_i;
      assign den_in = den_i;
      assign sb_in  = sb_i;
      assign quo_in = '0;
      for (genvar l = 0; l < LANES; l++) begin : g_init
        assign rem_in[l] = (DW + 1)'(num_i[l][NW-1:QW]);
      end
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign sb_in  = sb_q[k-1];
      assign quo_in = quo_q[k-1];
      assign rem_in = rem_q[k-1];
    end

    always_comb begin
      logic [DW:0] rr;
      for (int l = 0; l < LANES; l++) begin
        rr = {rem_in[l][DW-1:0], num_in[l][QW-1-k]};
        if (rr >= {1'b0, den_in}) begin
          rem_d[l] = rr - {1'b0, den_in};
          quo_d[l] = {quo_in[l][QW-2:0], 1'b1};
        end else begin
          rem_d[l] = rr;
          quo_d[l] = {quo_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= num_in;
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        den_q[k] <= den_in;
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign sb_o    = sb_q[QW-1];

endmodule

`default_nettype wire

FILE: sv/bezier_inner_control_point_unit.sv
// Inner Bezier control point unit: top level pipeline.
//
// Input channel: one word per accepted cycle (in_valid_i high, in_stall_o low) carries
// the end point, the opposite end point and the normal at the end point, signed Q16.16.
// Output channel: one word per item (out_valid_o high, out_stall_i low) carries the
// saturated handle point and the degenerate flag (handle equals the end point then).
// From acceptance to out_valid_o a word passes three front stages, a 32-stage
// square root for the end-to-end distance, nine projection and reduction stages, a
// 29-stage square root for the direction length, two scaling stages, a 32-stage
// three-lane divider and the output register.
// Throughput is one word per cycle unless stalled; all stages advance together.
// When the output register holds a word and out_stall_i is high, every stage holds and
// in_stall_o rises; nothing is dropped or repeated. Words move on when the stall clears.
// Reset clears the valid bits of all stages; data registers are not reset.
`default_nettype none

module bezier_inner_control_point_unit
  import bicp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] main_x_i,
  input  logic signed [31:0] main_y_i,
  input  logic signed [31:0] main_z_i,
  input  logic signed [31:0] other_x_i,
  input  logic signed [31:0] other_y_i,
  input  logic signed [31:0] other_z_i,
  input  logic signed [31:0] normal_x_i,
  input  logic signed [31:0] normal_y_i,
  input  logic signed [31:0] normal_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] handle_x_o,
  output logic signed [31:0] handle_y_o,
  output logic signed [31:0] handle_z_o,
  output logic               degenerate_o
);

  typedef struct packed {
    logic [2:0][31:0] m;
    logic [2:0][19:0] n;
    logic [2:0][19:0] d;
  } sb1_t;

  typedef struct packed {
    logic [2:0][31:0] m;
    logic [2:0]       wneg;
    logic [2:0][27:0] wmag;
    logic [32:0]      len;
    logic             degen;
  } sb2_t;

  typedef struct packed {
    logic [2:0][31:0] m;
    logic [2:0]       wneg;
    logic             degen;
  } sb3_t;

  logic en;
  logic [2:0][31:0] in_m, in_p, in_n;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  assign in_m = {main_z_i, main_y_i, main_x_i};
  assign in_p = {other_z_i, other_y_i, other_x_i};
  assign in_n = {normal_z_i, normal_y_i, normal_x_i};

  // Front: difference and magnitudes.
  logic             a_v_q;
  logic [2:0][31:0] a_m_q, a_dmag_q, a_nmag_q, a_dmag_d, a_nmag_d;
  logic [2:0]       a_dneg_q, a_nneg_q, a_dneg_d, a_nneg_d;

  always_comb begin
    logic [32:0] diff;
    logic [32:0] dabs;
    for (int i = 0; i < 3; i++) begin
      diff        = {in_p[i][31], in_p[i]} - {in_m[i][31], in_m[i]};
      dabs        = diff[32] ? (33'd0 - diff) : diff;
      a_dneg_d[i] = diff[32];
      a_dmag_d[i] = dabs[31:0];
      a_nneg_d[i] = in_n[i][31];
      a_nmag_d[i] = in_n[i][31] ? (32'd0 - in_n[i]) : in_n[i];
    end
  end

  // Squares for the distance and shift amounts for the reductions.
  logic             b_v_q;
  logic [2:0][31:0] b_m_q, b_dmag_q, b_nmag_q;
  logic [2:0]       b_dneg_q, b_nneg_q;
  logic [2:0][61:0] b_sq_q, b_sq_d;
  logic [5:0]       b_nsh_q, b_dsh_q, b_nsh_d, b_dsh_d;

  always_comb begin
    logic [63:0] prod;
    for (int i = 0; i < 3; i++) begin
      prod      = a_dmag_q[i] * a_dmag_q[i];
      b_sq_d[i] = prod[63:2];
    end
    b_nsh_d = fit_shift({32'd0, a_nmag_q[0] | a_nmag_q[1] | a_nmag_q[2]}, NORM_BITS);
    b_dsh_d = fit_shift({32'd0, a_dmag_q[0] | a_dmag_q[1] | a_dmag_q[2]}, NORM_BITS);
  end

  // Sum of squares and reduced normal and difference.
  logic             c_v_q;
  logic [2:0][31:0] c_m_q;
  logic [63:0]      c_q_q, c_q_d;
  logic [2:0][19:0] c_n_q, c_d_q, c_n_d, c_d_d;

  always_comb begin
    logic [31:0] sn, sd;
    logic [19:0] vn, vd;
    c_q_d = {2'b0, b_sq_q[0]} + {2'b0, b_sq_q[1]} + {2'b0, b_sq_q[2]};
    for (int i = 0; i < 3; i++) begin
      sn       = b_nmag_q[i] >> b_nsh_q;
      sd       = b_dmag_q[i] >> b_dsh_q;
      vn       = {1'b0, sn[18:0]};
      vd       = {1'b0, sd[18:0]};
      c_n_d[i] = b_nneg_q[i] ? (20'd0 - vn) : vn;
      c_d_d[i] = b_dneg_q[i] ? (20'd0 - vd) : vd;
    end
  end

  sb1_t        r1_sb_in, r1_sb;
  logic        r1_v;
  logic [31:0] r1_root;

  assign r1_sb_in = '{m: c_m_q, n: c_n_q, d: c_d_q};

  bicp_isqrt #(
    .IW (64),
    .SW ($bits(sb1_t))
  ) u_len_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_v_q),
    .rad_i   (c_q_q),
    .sb_i    (r1_sb_in),
    .valid_o (r1_v),
    .root_o  (r1_root),
    .sb_o    (r1_sb)
  );

  // Products for n.n and n.d.
  logic             e_v_q;
  sb1_t             e_sb_q;
  logic [32:0]      e_len_q;
  logic [2:0][39:0] e_nnp_q, e_ndp_q, e_nnp_d, e_ndp_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_nnp_d[i] = $signed(r1_sb.n[i]) * $signed(r1_sb.n[i]);
      e_ndp_d[i] = $signed(r1_sb.n[i]) * $signed(r1_sb.d[i]);
    end
  end

  // Dot product sums.
  logic        f_v_q;
  sb1_t        f_sb_q;
  logic [32:0] f_len_q;
  logic signed [41:0] f_nn_q, f_nd_q, f_nn_d, f_nd_d;

  assign f_nn_d = $signed(e_nnp_q[0]) + $signed(e_nnp_q[1]) + $signed(e_nnp_q[2]);
  assign f_nd_d = $signed(e_ndp_q[0]) + $signed(e_ndp_q[1]) + $signed(e_ndp_q[2]);

  // Projection products.
  logic             g_v_q, g_degen_q, g_degen_d;
  logic [2:0][31:0] g_m_q;
  logic [32:0]      g_len_q;
  logic [2:0][61:0] g_w1_q, g_w2_q, g_w1_d, g_w2_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_w1_d[i] = $signed(f_sb_q.d[i]) * f_nn_q;
      g_w2_d[i] = $signed(f_sb_q.n[i]) * f_nd_q;
    end
    g_degen_d = (f_nn_q == '0);
  end

  // Projected direction.
  logic             h_v_q, h_degen_q;
  logic [2:0][31:0] h_m_q;
  logic [32:0]      h_len_q;
  logic [2:0][62:0] h_w_q, h_w_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_w_d[i] = $signed(g_w1_q[i]) - $signed(g_w2_q[i]);
    end
  end

  // Direction sign and magnitude, zero check.
  logic             i_v_q, i_degen_q, i_degen_d;
  logic [2:0][31:0] i_m_q;
  logic [32:0]      i_len_q;
  logic [2:0]       i_wneg_q, i_wneg_d;
  logic [2:0][61:0] i_wmag_q, i_wmag_d;

  always_comb begin
    logic [62:0] wa;
    for (int i = 0; i < 3; i++) begin
      wa          = h_w_q[i][62] ? (63'd0 - h_w_q[i]) : h_w_q[i];
      i_wneg_d[i] = h_w_q[i][62];
      i_wmag_d[i] = wa[61:0];
    end
    i_degen_d = h_degen_q || (h_w_q == '0);
  end

  // Direction reduction shift.
  logic             j_v_q, j_degen_q;
  logic [2:0][31:0] j_m_q;
  logic [32:0]      j_len_q;
  logic [2:0]       j_wneg_q;
  logic [2:0][61:0] j_wmag_q;
  logic [5:0]       j_sh_q, j_sh_d;

  assign j_sh_d = fit_shift({2'b0, i_wmag_q[0] | i_wmag_q[1] | i_wmag_q[2]}, DIR_BITS);

  // Reduced direction.
  logic             k_v_q, k_degen_q;
  logic [2:0][31:0] k_m_q;
  logic [32:0]      k_len_q;
  logic [2:0]       k_wneg_q;
  logic [2:0][27:0] k_wmag_q, k_wmag_d;

  always_comb begin
    logic [61:0] ws;
    for (int i = 0; i < 3; i++) begin
      ws          = j_wmag_q[i] >> j_sh_q;
      k_wmag_d[i] = ws[27:0];
    end
  end

  // Squares of the reduced direction.
  logic             l_v_q, l_degen_q;
  logic [2:0][31:0] l_m_q;
  logic [32:0]      l_len_q;
  logic [2:0]       l_wneg_q;
  logic [2:0][27:0] l_wmag_q;
  logic [2:0][55:0] l_sq_q, l_sq_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      l_sq_d[i] = k_wmag_q[i] * k_wmag_q[i];
    end
  end

  // Squared direction length.
  logic        s_v_q;
  sb2_t        s_sb_q, s_sb_d;
  logic [57:0] s_ss_q, s_ss_d;

  assign s_ss_d = {2'b0, l_sq_q[0]} + {2'b0, l_sq_q[1]} + {2'b0, l_sq_q[2]};
  assign s_sb_d = '{m: l_m_q, wneg: l_wneg_q, wmag: l_wmag_q, len: l_len_q,
                    degen: l_degen_q};

  sb2_t        r2_sb;
  logic        r2_v;
  logic [28:0] r2_root;

  bicp_isqrt #(
    .IW (58),
    .SW ($bits(sb2_t))
  ) u_dir_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_v_q),
    .rad_i   (s_ss_q),
    .sb_i    (s_sb_q),
    .valid_o (r2_v),
    .root_o  (r2_root),
    .sb_o    (r2_sb)
  );

  // Divisor and scaled numerators.
  logic             o_v_q;
  sb3_t             o_sb_q, o_sb_d;
  logic [30:0]      o_den_q, o_den_d;
  logic [2:0][60:0] o_p_q, o_p_d;

  always_comb begin
    logic [28:0] mg;
    mg      = (r2_root == '0) ? 29'd1 : r2_root;
    o_den_d = {2'b0, mg} * THIRD_DIV;
    for (int i = 0; i < 3; i++) begin
      o_p_d[i] = r2_sb.wmag[i] * r2_sb.len;
    end
  end

  assign o_sb_d = '{m: r2_sb.m, wneg: r2_sb.wneg, degen: r2_sb.degen};

  // Rounding offset.
  logic             p_v_q;
  sb3_t             p_sb_q;
  logic [30:0]      p_den_q;
  logic [2:0][61:0] p_x_q, p_x_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_x_d[i] = {1'b0, o_p_q[i]} + {32'd0, o_den_q[30:1]};
    end
  end

  sb3_t             dv_sb;
  logic             dv_v;
  logic [2:0][31:0] dv_quo;

  bicp_div #(
    .LANES (3),
    .NW    (62),
    .DW    (31),
    .QW    (32),
    .SW    ($bits(sb3_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_v_q),
    .num_i   (p_x_q),
    .den_i   (p_den_q),
    .sb_i    (p_sb_q),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .sb_o    (dv_sb)
  );

  // Offset, saturate, output register.
  logic             out_v_q, out_deg_q;
  logic [2:0][31:0] out_h_q, out_h_d;

  always_comb begin
    logic signed [33:0] q, r;
    for (int i = 0; i < 3; i++) begin
      q = $signed({2'b0, dv_quo[i]});
      r = $signed(dv_sb.m[i]) + (dv_sb.wneg[i] ? -q : q);
      if (dv_sb.degen) begin
        out_h_d[i] = dv_sb.m[i];
      end else if (r > 34'sh0_7FFF_FFFF) begin
        out_h_d[i] = 32'h7FFF_FFFF;
      end else if (r < -34'sh0_8000_0000) begin
        out_h_d[i] = 32'h8000_0000;
      end else begin
        out_h_d[i] = r[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      e_v_q   <= 1'b0;
      f_v_q   <= 1'b0;
      g_v_q   <= 1'b0;
      h_v_q   <= 1'b0;
      i_v_q   <= 1'b0;
      j_v_q   <= 1'b0;
      k_v_q   <= 1'b0;
      l_v_q   <= 1'b0;
      s_v_q   <= 1'b0;
      o_v_q   <= 1'b0;
      p_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      a_v_q   <= in_valid_i;
      b_v_q   <= a_v_q;
      c_v_q   <= b_v_q;
      e_v_q   <= r1_v;
      f_v_q   <= e_v_q;
      g_v_q   <= f_v_q;
      h_v_q   <= g_v_q;
      i_v_q   <= h_v_q;
      j_v_q   <= i_v_q;
      k_v_q   <= j_v_q;
      l_v_q   <= k_v_q;
      s_v_q   <= l_v_q;
      o_v_q   <= r2_v;
      p_v_q   <= o_v_q;
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_m_q     <= in_m;
      a_dmag_q  <= a_dmag_d;
      a_nmag_q  <= a_nmag_d;
      a_dneg_q  <= a_dneg_d;
      a_nneg_q  <= a_nneg_d;
      b_m_q     <= a_m_q;
      b_dmag_q  <= a_dmag_q;
      b_nmag_q  <= a_nmag_q;
      b_dneg_q  <= a_dneg_q;
      b_nneg_q  <= a_nneg_q;
      b_sq_q    <= b_sq_d;
      b_nsh_q   <= b_nsh_d;
      b_dsh_q   <= b_dsh_d;
      c_m_q     <= b_m_q;
      c_q_q     <= c_q_d;
      c_n_q     <= c_n_d;
      c_d_q     <= c_d_d;
      e_sb_q    <= r1_sb;
      e_len_q   <= {r1_root, 1'b0};
      e_nnp_q   <= e_nnp_d;
      e_ndp_q   <= e_ndp_d;
      f_sb_q    <= e_sb_q;
      f_len_q   <= e_len_q;
      f_nn_q    <= f_nn_d;
      f_nd_q    <= f_nd_d;
      g_m_q     <= f_sb_q.m;
      g_len_q   <= f_len_q;
      g_w1_q    <= g_w1_d;
      g_w2_q    <= g_w2_d;
      g_degen_q <= g_degen_d;
      h_m_q     <= g_m_q;
      h_len_q   <= g_len_q;
      h_w_q     <= h_w_d;
      h_degen_q <= g_degen_q;
      i_m_q     <= h_m_q;
      i_len_q   <= h_len_q;
      i_wneg_q  <= i_wneg_d;
      i_wmag_q  <= i_wmag_d;
      i_degen_q <= i_degen_d;
      j_m_q     <= i_m_q;
      j_len_q   <= i_len_q;
      j_wneg_q  <= i_wneg_q;
      j_wmag_q  <= i_wmag_q;
      j_degen_q <= i_degen_q;
      j_sh_q    <= j_sh_d;
      k_m_q     <= j_m_q;
      k_len_q   <= j_len_q;
      k_wneg_q  <= j_wneg_q;
      k_wmag_q  <= k_wmag_d;
      k_degen_q <= j_degen_q;
      l_m_q     <= k_m_q;
      l_len_q   <= k_len_q;
      l_wneg_q  <= k_wneg_q;
      l_wmag_q  <= k_wmag_q;
      l_degen_q <= k_degen_q;
      l_sq_q    <= l_sq_d;
      s_sb_q    <= s_sb_d;
      s_ss_q    <= s_ss_d;
      o_sb_q    <= o_sb_d;
      o_den_q   <= o_den_d;
      o_p_q     <= o_p_d;
      p_sb_q    <= o_sb_q;
      p_den_q   <= o_den_q;
      p_x_q     <= p_x_d;
      out_h_q   <= out_h_d;
      out_deg_q <= dv_sb.degen;
    end
  end

  assign out_valid_o  = out_v_q;
  assign handle_x_o   = out_h_q[0];
  assign handle_y_o   = out_h_q[1];
  assign handle_z_o   = out_h_q[2];
  assign degenerate_o = out_deg_q;

  a_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q |-> o_den_q != '0)
    else $error("zero divisor entering the divider");

  a_reduce_keeps_dir : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_v_q && !k_degen_q) |-> k_wmag_q != '0)
    else $error("direction reduced to zero without degenerate flag");

  a_stall_only_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output can drain");

endmodule

`default_nettype wire
